// ----- rtl/lsl_pkg.sv -----
// Shared constants, coefficient tables and stage types for the lux calculation pipeline.
`default_nettype none
package lsl_pkg;

  localparam int CNT_W    = 16;
  localparam int PROD_W   = 2 * CNT_W;
  localparam int SCALE_SH = 10;
  localparam int SC_W     = PROD_W - SCALE_SH;
  localparam int REM_W    = SC_W + 1;
  localparam int QUO_W    = 11;
  localparam int COEF_W   = 10;
  localparam int TERM_W   = SC_W + COEF_W;
  localparam int LUX_SH   = 14;
  localparam int LUX_W    = 18;
  localparam int SEG_NUM  = 8;
  localparam int SEG_W    = 3;

  localparam logic [CNT_W-1:0]  SCALE_RESET = 16'hFE70;
  localparam logic [TERM_W:0]   LUX_ROUND   = (TERM_W + 1)'(1 << (LUX_SH - 1));

  typedef logic [COEF_W-1:0] coef_t;

  localparam coef_t SEG_LIMIT [0:SEG_NUM-2] = '{
    10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A
  };
  localparam coef_t SEG_ICPT [0:SEG_NUM-1] = '{
    10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000
  };
  localparam coef_t SEG_SLOPE [0:SEG_NUM-1] = '{
    10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000
  };

  typedef struct packed {
    logic [SC_W-1:0]  sc0;
    logic [SC_W-1:0]  sc1;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             zero;
  } div_t;

endpackage
`default_nettype wire

// ----- rtl/lsl_div_cell.sv -----
// One restoring-division cell: resolves one ratio quotient bit and hands the beat on.
`default_nettype none
module lsl_div_cell (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              valid_i,
  input  wire lsl_pkg::div_t data_i,
  input  wire              down_ld_i,
  output logic             ld_o,
  output logic             valid_o,
  output lsl_pkg::div_t    data_o
);

  logic                          valid_r;
  lsl_pkg::div_t                 data_r;
  lsl_pkg::div_t                 data_nxt;
  logic                          qbit;
  logic [lsl_pkg::REM_W-1:0]     diff;

  assign ld_o = !valid_r || down_ld_i;

  always_comb begin
    qbit     = data_i.rem >= {1'b0, data_i.sc0};
    diff     = qbit ? (data_i.rem - {1'b0, data_i.sc0}) : data_i.rem;
    data_nxt = data_i;
    data_nxt.rem = {diff[lsl_pkg::REM_W-2:0], 1'b0};
    data_nxt.quo = {data_i.quo[lsl_pkg::QUO_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule
`default_nettype wire

// ----- rtl/lsl_lux_tail.sv -----
// Segment pick, coefficient products and rounded lux output stage.
`default_nettype none
module lsl_lux_tail (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          valid_i,
  input  wire lsl_pkg::div_t           data_i,
  output logic                         ld_o,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [lsl_pkg::LUX_W-1:0]    out_lux
);

  logic                           ta_valid_r;
  logic [lsl_pkg::TERM_W-1:0]     term0_r;
  logic [lsl_pkg::TERM_W-1:0]     term1_r;
  logic                           out_valid_r;
  logic [lsl_pkg::LUX_W-1:0]      lux_r;
  logic                           ld_b;
  logic [lsl_pkg::SEG_W-1:0]      seg;
  logic [lsl_pkg::TERM_W-1:0]     term0_nxt;
  logic [lsl_pkg::TERM_W-1:0]     term1_nxt;
  logic [lsl_pkg::TERM_W-1:0]     diff;
  logic [lsl_pkg::TERM_W:0]       rnd;

  assign ld_b = !out_valid_r || out_ready;
  assign ld_o = !ta_valid_r || ld_b;

  always_comb begin
    seg = lsl_pkg::SEG_W'(lsl_pkg::SEG_NUM - 1);
    for (int k = lsl_pkg::SEG_NUM - 2; k >= 0; k--) begin
      if (data_i.quo <= {lsl_pkg::SEG_LIMIT[k], 1'b0}) begin
        seg = lsl_pkg::SEG_W'(k);
      end
    end
    if (data_i.zero) begin
      seg = '0;
    end else if (data_i.ovf) begin
      seg = lsl_pkg::SEG_W'(lsl_pkg::SEG_NUM - 1);
    end
    term0_nxt = lsl_pkg::TERM_W'(data_i.sc0) * lsl_pkg::TERM_W'(lsl_pkg::SEG_ICPT[seg]);
    term1_nxt = lsl_pkg::TERM_W'(data_i.sc1) * lsl_pkg::TERM_W'(lsl_pkg::SEG_SLOPE[seg]);
  end

  always_comb begin
    diff = (term0_r > term1_r) ? (term0_r - term1_r) : '0;
    rnd  = {1'b0, diff} + lsl_pkg::LUX_ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ta_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld_o) begin
        ta_valid_r <= valid_i;
      end
      if (ld_b) begin
        out_valid_r <= ta_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o && valid_i) begin
      term0_r <= term0_nxt;
      term1_r <= term1_nxt;
    end
    if (ld_b && ta_valid_r) begin
      lux_r <= rnd[lsl_pkg::LUX_SH +: lsl_pkg::LUX_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_lux   = lux_r;

endmodule
`default_nettype wire

// ----- rtl/light_sensor_lux_calc_unit.sv -----
// Path: a beat accepted into the scale multiply stage passes the ratio head,
// eleven divider cells and two tail stages before showing as out_valid.
// Throughput: one beat per cycle while out_ready is high; each stage holds one
// beat and advances when the next frees. Reset: synchronous active-low rst_n
// clears every stage valid and loads scale_r with 0xFE70.
`default_nettype none
module light_sensor_lux_calc_unit (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire [lsl_pkg::CNT_W-1:0]     cfg_wr_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [lsl_pkg::CNT_W-1:0]     in_broadband_count,
  input  wire [lsl_pkg::CNT_W-1:0]     in_infrared_count,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [lsl_pkg::LUX_W-1:0]    out_lux
);

  logic [lsl_pkg::CNT_W-1:0]   scale_r;
  logic                        s1_valid_r;
  logic [lsl_pkg::PROD_W-1:0]  p0_r;
  logic [lsl_pkg::PROD_W-1:0]  p1_r;
  logic                        s1_ld;
  logic                        s2_valid_r;
  lsl_pkg::div_t               s2_r;
  lsl_pkg::div_t               s2_nxt;
  logic                        s2_ld;
  logic [lsl_pkg::SC_W-1:0]    sc0;
  logic [lsl_pkg::SC_W-1:0]    sc1;

  lsl_pkg::div_t               cell_d [0:lsl_pkg::QUO_W];
  logic                        cell_v [0:lsl_pkg::QUO_W];
  logic                        ld_w   [0:lsl_pkg::QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= lsl_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  assign s1_ld    = !s1_valid_r || s2_ld;
  assign s2_ld    = !s2_valid_r || ld_w[0];
  assign in_ready = s1_ld;

  always_comb begin
    sc0 = p0_r[lsl_pkg::SCALE_SH +: lsl_pkg::SC_W];
    sc1 = p1_r[lsl_pkg::SCALE_SH +: lsl_pkg::SC_W];
    s2_nxt.sc0  = sc0;
    s2_nxt.sc1  = sc1;
    s2_nxt.rem  = {1'b0, sc1};
    s2_nxt.quo  = '0;
    s2_nxt.zero = sc0 == '0;
    s2_nxt.ovf  = {1'b0, sc1} >= {sc0, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ld) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) begin
      p0_r <= lsl_pkg::PROD_W'(in_broadband_count) * lsl_pkg::PROD_W'(scale_r);
      p1_r <= lsl_pkg::PROD_W'(in_infrared_count) * lsl_pkg::PROD_W'(scale_r);
    end
    if (s2_ld && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign cell_d[0] = s2_r;
  assign cell_v[0] = s2_valid_r;

  for (genvar k = 0; k < lsl_pkg::QUO_W; k++) begin : g_cell
    lsl_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_i   (cell_v[k]),
      .data_i    (cell_d[k]),
      .down_ld_i (ld_w[k+1]),
      .ld_o      (ld_w[k]),
      .valid_o   (cell_v[k+1]),
      .data_o    (cell_d[k+1])
    );
  end

  lsl_lux_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (cell_v[lsl_pkg::QUO_W]),
    .data_i    (cell_d[lsl_pkg::QUO_W]),
    .ld_o      (ld_w[lsl_pkg::QUO_W]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_lux   (out_lux)
  );

endmodule
`default_nettype wire

// ----- tb/light_sensor_lux_calc_unit_tb.sv -----
// Self-checking testbench for the lux calculation pipeline: directed table, random pairs.
`default_nettype none
module light_sensor_lux_calc_unit_tb;

  localparam int LAT_WAIT    = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 300;

  typedef struct packed {
    logic [lsl_pkg::CNT_W-1:0] bb;
    logic [lsl_pkg::CNT_W-1:0] ir;
    logic                      known;
    logic [lsl_pkg::LUX_W-1:0] lux;
  } lux_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [lsl_pkg::CNT_W-1:0] cfg_wr_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [lsl_pkg::CNT_W-1:0] in_broadband_count;
  logic [lsl_pkg::CNT_W-1:0] in_infrared_count;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [lsl_pkg::LUX_W-1:0] out_lux;

  logic [lsl_pkg::CNT_W-1:0] scale_reg = 16'hFE70;
  logic [lsl_pkg::LUX_W-1:0] lux_q [$];
  logic [lsl_pkg::LUX_W-1:0] want_lux;
  logic                      steady = 1'b0;
  int                        errors = 0;
  int                        cycles = 0;

  int unsigned bend_ratio [7] = '{'h040, 'h080, 'h0C0, 'h100, 'h138, 'h19A, 'h29A};
  int unsigned bb_coef    [8] = '{'h1F2, 'h214, 'h23F, 'h270, 'h16F, 'h0D2, 'h018, 'h000};
  int unsigned ir_coef    [8] = '{'h1BE, 'h2D1, 'h37B, 'h3FE, 'h1FC, 'h0FB, 'h012, 'h000};

  lux_row_t lux_rows [22] = '{
    '{16'h0000, 16'h0000, 1'b1, 18'd0},
    '{16'h0000, 16'hFFFF, 1'b1, 18'd0},
    '{16'h0001, 16'hFFFF, 1'b1, 18'd0},
    '{16'h8000, 16'hFFFF, 1'b1, 18'd0},
    '{16'hFFFF, 16'h0000, 1'b0, 18'd0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 18'd0},
    '{16'hFFFF, 16'h8000, 1'b0, 18'd0},
    '{16'h0001, 16'h0000, 1'b0, 18'd0},
    '{16'd4096, 16'd512,  1'b0, 18'd0},
    '{16'd4096, 16'd516,  1'b0, 18'd0},
    '{16'd4096, 16'd1024, 1'b0, 18'd0},
    '{16'd4096, 16'd1028, 1'b0, 18'd0},
    '{16'd4096, 16'd1536, 1'b0, 18'd0},
    '{16'd4096, 16'd1540, 1'b0, 18'd0},
    '{16'd4096, 16'd2048, 1'b0, 18'd0},
    '{16'd4096, 16'd2052, 1'b0, 18'd0},
    '{16'd4096, 16'd2496, 1'b0, 18'd0},
    '{16'd4096, 16'd2500, 1'b0, 18'd0},
    '{16'd4096, 16'd3280, 1'b0, 18'd0},
    '{16'd4096, 16'd3284, 1'b0, 18'd0},
    '{16'd4096, 16'd5328, 1'b0, 18'd0},
    '{16'd4096, 16'd5332, 1'b0, 18'd0}
  };

  light_sensor_lux_calc_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_broadband_count (in_broadband_count),
    .in_infrared_count  (in_infrared_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lux            (out_lux)
  );

  always #1 clk = ~clk;

  function automatic logic [lsl_pkg::LUX_W-1:0] lux_of_w(input logic [63:0] diff);
    logic [63:0] r;
    r = (diff + 64'd8192) >> 14;
    return r[lsl_pkg::LUX_W-1:0];
  endfunction

  function automatic logic [lsl_pkg::LUX_W-1:0] lux_of(input logic [15:0] bb,
                                                       input logic [15:0] ir,
                                                       input logic [15:0] scale);
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] ratio;
    logic [63:0] t0;
    logic [63:0] t1;
    logic [63:0] diff;
    int          seg;
    s0 = (64'(bb) * 64'(scale)) >> 10;
    s1 = (64'(ir) * 64'(scale)) >> 10;
    ratio = 64'd0;
    if (s0 != 0) begin
      ratio = (((s1 << 10) / s0) + 64'd1) >> 1;
    end
    seg = 7;
    for (int k = 6; k >= 0; k--) begin
      if (ratio <= 64'(bend_ratio[k])) seg = k;
    end
    t0 = s0 * 64'(bb_coef[seg]);
    t1 = s1 * 64'(ir_coef[seg]);
    diff = (t0 > t1) ? t0 - t1 : 64'd0;
    return lux_of_w(diff);
  endfunction

  task automatic send_pair(input logic [15:0] bb, input logic [15:0] ir,
                           input logic known, input logic [lsl_pkg::LUX_W-1:0] lux);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_broadband_count <= bb;
    in_infrared_count  <= ir;
    do @(posedge clk); while (!in_ready);
    lux_q.push_back(known ? lux : lux_of(bb, ir, scale_reg));
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lux_q.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_scale(input logic [15:0] v);
    drain_pipe();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    scale_reg = v;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d beats outstanding", $time, lux_q.size());
      $display("*** FAILED ***");
      $finish;
    end
    out_ready <= steady || ($urandom_range(99) >= 7);
    if (rst_n && out_valid && out_ready) begin
      if (lux_q.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual lux %0d", $time, out_lux);
        errors++;
      end else begin
        want_lux = lux_q.pop_front();
        if (want_lux !== out_lux) begin
          $display("%0t lux mismatch: expected %0d, actual %0d", $time, want_lux, out_lux);
          errors++;
        end
      end
    end
  end

  initial begin : stim
    logic [15:0] scales [7];
    logic [15:0] bb;
    logic [15:0] ir;
    logic [31:0] tmp;
    int          lim;
    scales = '{16'h0400, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'hFE70};
    scales[4] = 16'($urandom);
    scales[5] = 16'($urandom_range(256, 4096));
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_valid           <= 1'b0;
    in_broadband_count <= '0;
    in_infrared_count  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (lux_rows[i]) begin
      send_pair(lux_rows[i].bb, lux_rows[i].ir, lux_rows[i].known, lux_rows[i].lux);
    end

    foreach (scales[p]) begin
      write_scale(scales[p]);
      steady = (p == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        case ($urandom_range(3))
          0: begin
            bb = 16'($urandom);
            ir = 16'($urandom);
          end
          1: begin
            bb  = 16'($urandom);
            tmp = (32'(bb) * $urandom_range(0, 1400)) >> 10;
            ir  = (tmp > 32'hFFFF) ? 16'hFFFF : tmp[15:0];
          end
          2: begin
            bb = 16'($urandom_range(0, 64));
            ir = 16'($urandom_range(0, 64));
          end
          default: begin
            bb  = 16'($urandom_range(1, 65535));
            lim = bend_ratio[$urandom_range(0, 6)];
            tmp = ((32'(bb) * 32'(lim)) >> 9) + $urandom_range(0, 4);
            tmp = (tmp >= 2) ? tmp - 2 : 32'd0;
            ir  = (tmp > 32'hFFFF) ? 16'hFFFF : tmp[15:0];
          end
        endcase
        send_pair(bb, ir, 1'b0, '0);
      end
    end

    steady = 1'b0;
    drain_pipe();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/lsl_pkg.sv
rtl/lsl_div_cell.sv
rtl/lsl_lux_tail.sv
rtl/light_sensor_lux_calc_unit.sv
tb/light_sensor_lux_calc_unit_tb.sv
